// ===== rtl/bsap_pkg.sv =====
// Shared types and constants for the bulk string array parser.
// No dependencies.
package bsap_pkg;

  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  typedef struct packed {
    logic [1:0]  rec_kind;
    logic [31:0] arg_count;
    logic [31:0] arg_index;
    logic [7:0]  data_byte;
    logic        last_of_arg;
    logic        last_of_message;
  } rec_t;

endpackage

// ===== rtl/bulk_string_array_parser.sv =====
// Top level of the bulk string array parser: input register, parser core, result register.
// Depends on bsap_pkg and bsap_core.
//
//  channel | dir | fields
//  s_*     | in  | tdata[7:0] in_byte
//  m_*     | out | tdata: arg_count, arg_index, data_byte; tuser: rec_kind, last_of_arg;
//          |     | tlast: last_of_message
//
// One byte per cycle unless m_tready stalls; m_tvalid is driven by the result register.
// The parser state advances once per byte in a single pass of the core logic.
// Reset (rst, synchronous) empties both registers and returns to waiting for '*'.
// A stall on m_tready holds the result register and, while it holds a byte, the input.
module bulk_string_array_parser
  import bsap_pkg::*;
#(
  parameter int NUM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] arg_count, [63:32] arg_index, [71:64] data_byte
  output logic [2:0]  m_tuser,   // [1:0] rec_kind, [2] last_of_arg
  output logic        m_tlast    // last_of_message
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       rec_valid;
  rec_t       rec;
  rec_t       out_rec;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready) begin
      in_byte <= s_tdata;
    end
  end

  bsap_core #(
    .NUM_BITS(NUM_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (in_valid && advance),
    .in_byte  (in_byte),
    .rec_valid(rec_valid),
    .rec      (rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && rec_valid;
    end
    if (advance) begin
      out_rec <= rec;
    end
  end

  assign m_tdata = {out_rec.data_byte, out_rec.arg_index, out_rec.arg_count};
  assign m_tuser = {out_rec.last_of_arg, out_rec.rec_kind};
  assign m_tlast = out_rec.last_of_message;

endmodule

// ===== rtl/bsap_core.sv =====
// Parser state and per-byte step logic for the bulk string array parser.
// Depends on bsap_pkg.
module bsap_core
  import bsap_pkg::*;
#(
  parameter int NUM_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  output logic       rec_valid,
  output rec_t       rec
);

  typedef enum logic [3:0] {
    PH_WAIT_ARRAY,
    PH_COUNT,
    PH_COUNT_SKIP,
    PH_WAIT_DOLLAR,
    PH_LEN,
    PH_LEN_SKIP,
    PH_PAYLOAD,
    PH_TRAIL1,
    PH_TRAIL2
  } phase_t;

  phase_t              phase;
  logic [NUM_BITS-1:0] number_accum;
  logic [31:0]         args_remaining;
  logic [31:0]         current_arg;
  logic [31:0]         bytes_remaining;
  logic [31:0]         parsed_count;

  logic [NUM_BITS-1:0] accum_next;
  logic [31:0]         number_low;

  // acc*10 + c - '0', wrapping
  assign accum_next = (number_accum << 3) + (number_accum << 1)
                    + NUM_BITS'(in_byte) - NUM_BITS'(CH_ZERO);
  assign number_low = 32'(number_accum);

  always_comb begin
    rec_valid           = 1'b0;
    rec.rec_kind        = KIND_HEADER;
    rec.arg_count       = parsed_count;
    rec.arg_index       = '0;
    rec.data_byte       = '0;
    rec.last_of_arg     = 1'b0;
    rec.last_of_message = 1'b0;
    unique case (phase)
      PH_COUNT_SKIP: begin
        rec_valid           = 1'b1;
        rec.arg_count       = number_low;
        rec.last_of_message = (number_low == '0);
      end
      PH_LEN_SKIP: begin
        rec_valid           = (number_low == '0);
        rec.rec_kind        = KIND_EMPTY;
        rec.arg_index       = current_arg;
        rec.last_of_arg     = 1'b1;
        rec.last_of_message = (args_remaining == 32'd1);
      end
      PH_PAYLOAD: begin
        rec_valid           = 1'b1;
        rec.rec_kind        = KIND_DATA;
        rec.arg_index       = current_arg;
        rec.data_byte       = in_byte;
        rec.last_of_arg     = (bytes_remaining == 32'd1);
        rec.last_of_message = (bytes_remaining == 32'd1) && (args_remaining == 32'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT_ARRAY;
      number_accum    <= '0;
      args_remaining  <= '0;
      current_arg     <= '0;
      bytes_remaining <= '0;
      parsed_count    <= '0;
    end else if (step) begin
      unique case (phase)
        PH_WAIT_ARRAY: begin
          if (in_byte == CH_STAR) begin
            number_accum <= '0;
            phase        <= PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (in_byte == CH_CR) phase <= PH_COUNT_SKIP;
          else number_accum <= accum_next;
        end
        PH_COUNT_SKIP: begin
          parsed_count   <= number_low;
          args_remaining <= number_low;
          current_arg    <= '0;
          phase          <= (number_low == '0) ? PH_WAIT_ARRAY : PH_WAIT_DOLLAR;
        end
        PH_WAIT_DOLLAR: begin
          if (in_byte == CH_DOLLAR) begin
            number_accum <= '0;
            phase        <= PH_LEN;
          end
        end
        PH_LEN: begin
          if (in_byte == CH_CR) phase <= PH_LEN_SKIP;
          else number_accum <= accum_next;
        end
        PH_LEN_SKIP: begin
          bytes_remaining <= number_low;
          phase           <= (number_low == '0) ? PH_TRAIL1 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          bytes_remaining <= bytes_remaining - 32'd1;
          if (bytes_remaining == 32'd1) phase <= PH_TRAIL1;
        end
        PH_TRAIL1: begin
          phase <= PH_TRAIL2;
        end
        PH_TRAIL2: begin
          args_remaining <= args_remaining - 32'd1;
          current_arg    <= current_arg + 32'd1;
          phase          <= (args_remaining == 32'd1) ? PH_WAIT_ARRAY : PH_WAIT_DOLLAR;
        end
        default: begin
          phase <= PH_WAIT_ARRAY;
        end
      endcase
    end
  end

endmodule

// ===== test/tb_bulk_string_array_parser.sv =====
`timescale 1ns / 100ps
// Testbench for bulk_string_array_parser: streams array-of-bulk-string requests byte by byte
// and checks every output record against an in-bench parser model.
// Depends on bsap_pkg and the bulk_string_array_parser RTL.
module tb_bulk_string_array_parser;
  import bsap_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 900;

  typedef enum logic [3:0] {
    P_WAIT_ARRAY, P_COUNT, P_COUNT_SKIP, P_WAIT_DOLLAR, P_LEN, P_LEN_SKIP,
    P_PAYLOAD, P_TRAIL1, P_TRAIL2
  } parse_phase_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  // parser model state
  parse_phase_t parse_state = P_WAIT_ARRAY;
  logic [31:0]  accum      = '0;
  logic [31:0]  args_left  = '0;
  logic [31:0]  cur_arg    = '0;
  logic [31:0]  bytes_left = '0;
  logic [31:0]  msgs_done  = '0;
  logic [31:0]  count_val  = '0;
  rec_t         expected_records[$];

  bit calm            = 1'b0;
  int errors          = 0;
  int records_checked = 0;
  int useful_bytes    = 0;
  int bytes_sent      = 0;
  int cycles          = 0;
  int trunc_left      = -1;

  bulk_string_array_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  always @(negedge clk) m_tready <= calm || ($urandom_range(0, 99) >= 11);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0h, expected %0h (record %0d)",
                             name, got, want, records_checked));
    end
  endtask

  always @(posedge clk) begin : record_monitor
    rec_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (expected_records.size() == 0) begin
        report_error($sformatf("record with nothing pending: tdata %h tuser %h",
                               m_tdata, m_tuser));
      end else begin
        want = expected_records.pop_front();
        check_field("rec_kind", 32'(m_tuser[1:0]), 32'(want.rec_kind));
        check_field("arg_count", m_tdata[31:0], want.arg_count);
        check_field("arg_index", m_tdata[63:32], want.arg_index);
        check_field("data_byte", 32'(m_tdata[71:64]), 32'(want.data_byte));
        check_field("last_of_arg", 32'(m_tuser[2]), 32'(want.last_of_arg));
        check_field("last_of_message", 32'(m_tlast), 32'(want.last_of_message));
        records_checked++;
      end
    end
  end

  // Advances the model by one accepted byte and queues any record it yields.
  task automatic parse_byte(input logic [7:0] c);
    rec_t r;
    r = '0;
    r.arg_count = count_val;
    case (parse_state)
      P_WAIT_ARRAY: begin
        if (c == CH_STAR) begin
          accum = '0;
          parse_state = P_COUNT;
        end
      end
      P_COUNT: begin
        if (c == CH_CR) parse_state = P_COUNT_SKIP;
        else accum = accum * 32'd10 + {24'd0, c} - {24'd0, CH_ZERO};
      end
      P_COUNT_SKIP: begin
        count_val = accum;
        args_left = accum;
        cur_arg = '0;
        r.rec_kind = KIND_HEADER;
        r.arg_count = accum;
        if (accum == 0) begin
          r.last_of_message = 1'b1;
          msgs_done++;
          parse_state = P_WAIT_ARRAY;
        end else begin
          parse_state = P_WAIT_DOLLAR;
        end
        expected_records.push_back(r);
      end
      P_WAIT_DOLLAR: begin
        if (c == CH_DOLLAR) begin
          accum = '0;
          parse_state = P_LEN;
        end
      end
      P_LEN: begin
        if (c == CH_CR) parse_state = P_LEN_SKIP;
        else accum = accum * 32'd10 + {24'd0, c} - {24'd0, CH_ZERO};
      end
      P_LEN_SKIP: begin
        bytes_left = accum;
        if (accum == 0) begin
          r.rec_kind = KIND_EMPTY;
          r.arg_index = cur_arg;
          r.last_of_arg = 1'b1;
          r.last_of_message = (args_left == 1);
          expected_records.push_back(r);
          parse_state = P_TRAIL1;
        end else begin
          parse_state = P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        r.rec_kind = KIND_DATA;
        r.arg_index = cur_arg;
        r.data_byte = c;
        r.last_of_arg = (bytes_left == 1);
        r.last_of_message = (bytes_left == 1) && (args_left == 1);
        expected_records.push_back(r);
        bytes_left--;
        if (bytes_left == 0) parse_state = P_TRAIL1;
      end
      P_TRAIL1: parse_state = P_TRAIL2;
      P_TRAIL2: begin
        args_left--;
        cur_arg++;
        if (args_left == 0) begin
          msgs_done++;
          parse_state = P_WAIT_ARRAY;
        end else begin
          parse_state = P_WAIT_DOLLAR;
        end
      end
      default: parse_state = P_WAIT_ARRAY;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 11) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!((parse_state == P_WAIT_ARRAY && b != CH_STAR) ||
          (parse_state == P_WAIT_DOLLAR && b != CH_DOLLAR))) useful_bytes++;
    bytes_sent++;
    parse_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_eol(input logic [7:0] skip);
    send_byte(CH_CR);
    send_byte(skip);
  endtask

  function automatic logic [7:0] random_except(input logic [7:0] x);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == x);
    return v;
  endfunction

  // Drops bytes once a truncated request has run out.
  task automatic msg_byte(input logic [7:0] b);
    if (trunc_left != 0) begin
      send_byte(b);
      if (trunc_left > 0) trunc_left--;
    end
  endtask

  // Values 10..15 may go out as the single characters after '9'.
  task automatic send_number(input int v);
    if (v >= 10 && v <= 15 && $urandom_range(0, 1) == 1) begin
      msg_byte(8'(CH_ZERO + v));
    end else begin
      if ($urandom_range(0, 7) == 0) msg_byte(CH_ZERO);
      if (v >= 10) msg_byte(8'(CH_ZERO + v / 10));
      msg_byte(8'(CH_ZERO + v % 10));
    end
  endtask

  // Completes whatever request the parser is in; further arguments go out empty.
  task automatic drain_parser();
    int guard;
    guard = 0;
    while (parse_state != P_WAIT_ARRAY && guard < 4000) begin
      case (parse_state)
        P_COUNT, P_LEN: send_byte(CH_CR);
        P_WAIT_DOLLAR: send_byte(CH_DOLLAR);
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
      guard++;
    end
  endtask

  task automatic test_zero_count();
    send_text("PING");
    send_byte(CH_DOLLAR);
    send_text("*0");
    send_eol(8'h0A);
  endtask

  task automatic test_short_message();
    send_text("*2");
    send_eol(8'h0A);
    send_text("x");
    send_text("$3");
    send_eol(8'h0A);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_STAR);
    send_eol(8'h0A);
    send_text("$0");
    send_eol(8'h0A);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_wide_numbers();
    send_text("*4294967297");
    send_eol(8'hFF);
    send_text("$4294967298");
    send_eol(8'h00);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h7F);
    send_byte(8'h80);
  endtask

  task automatic test_non_digit_length();
    send_text("*1");
    send_eol(8'h0A);
    send_text("$:");
    send_eol(8'h0A);
    for (int i = 0; i < 10; i++) send_byte(8'(1 << (i % 8)));
    send_eol(8'h0A);
  endtask

  task automatic test_random_messages();
    int start_bytes;
    int n_args;
    int len;
    int msg_no;
    start_bytes = useful_bytes;
    msg_no = 0;
    while (useful_bytes - start_bytes < RANDOM_BYTES) begin
      calm = (msg_no >= 25 && msg_no < 40);
      drain_parser();
      trunc_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 24)) : -1;
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 6)) msg_byte(random_except(CH_STAR));
      end
      n_args = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      msg_byte(CH_STAR);
      send_number(n_args);
      msg_byte(CH_CR);
      msg_byte(8'($urandom_range(0, 255)));
      for (int a = 0; a < n_args; a++) begin
        if ($urandom_range(0, 9) == 0) msg_byte(random_except(CH_DOLLAR));
        case ($urandom_range(0, 19))
          0, 1, 2: len = 0;
          3: len = $urandom_range(20, 60);
          default: len = $urandom_range(1, 8);
        endcase
        msg_byte(CH_DOLLAR);
        send_number(len);
        msg_byte(CH_CR);
        msg_byte(8'($urandom_range(0, 255)));
        repeat (len) msg_byte(8'($urandom_range(0, 255)));
        msg_byte(8'($urandom_range(0, 255)));
        msg_byte(8'($urandom_range(0, 255)));
      end
      msg_no++;
    end
    calm = 1'b0;
    trunc_left = -1;
    drain_parser();
  endtask

  // Negative numbers wrap to huge unsigned values; the request never completes.
  task automatic test_wrapped_numbers();
    send_text("*-1");
    send_eol(8'h0A);
    send_text("$0");
    send_eol(8'h0A);
    send_eol(8'h0A);
    send_text("$-");
    send_eol(8'h0A);
    repeat (200) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_zero_count();
    test_short_message();
    test_wide_numbers();
    test_non_digit_length();
    test_random_messages();
    test_wrapped_numbers();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d request bytes, %0d messages completed, %0d records checked.",
             bytes_sent, msgs_done, records_checked);
    $display("Covered zero counts, empty args, wide and non-digit numbers,");
    $display("truncated and wrapped requests.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
